// ===== rtl/core/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement package
// Shared sizes, payload types and helpers for the page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

    // Number of physical frames and width of a page number.
    localparam int FRAME_COUNT = 16;
    localparam int PAGE_BITS   = 16;

    // Width of a frame index, and of a count that can hold FRAME_COUNT itself.
    localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);

    // Fixed field widths of the beats.
    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int FAULT_W = 32;
    localparam int CFG_W   = 5;

    // Reset value of the frames-in-use register.
    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [IDX_W-1:0]     idx_t;

    // One input beat.
    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              last_reference;
    } fpr_in_t;

    // One result beat.
    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               replaced_valid;
        logic [PAGE_W-1:0]  replaced_page;
        logic [FAULT_W-1:0] fault_count;
        logic               run_done;
    } fpr_out_t;

    // Per-cell controls broadcast from the top level.
    typedef struct packed {
        logic  in_range;
        logic  is_victim;
        logic  write;
        logic  clear;
        page_t page;
    } fpr_cell_ctl_t;

    // Data handed from one cell to the next along the row.
    typedef struct packed {
        logic  found;
        logic  rep_valid;
        page_t rep_page;
    } fpr_chain_t;

    // Low slot bits of a frame index.
    function automatic logic [SLOT_W-1:0] to_slot(input idx_t idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_W-1:0];
    endfunction

    // Page field of the output beat from an internal page.
    function automatic logic [PAGE_W-1:0] to_page_field(input page_t pg);
        logic [63:0] wide;
        wide = 64'(pg);
        return wide[PAGE_W-1:0];
    endfunction

    // Internal page from the input field, masked to PAGE_BITS.
    function automatic page_t from_page_field(input logic [PAGE_W-1:0] pf);
        logic [63:0] wide;
        wide = 64'(pf);
        return wide[PAGE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpr_cell.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement frame cell
// Holds one frame and its valid bit, compares it against the reference and
// passes match and victim data on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_cell
    import fpr_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fpr_cell_ctl_t ctl,
    input  wire fpr_chain_t    chain_in,
    output fpr_chain_t         chain_out,
    output logic               hit_here
);

    page_t page_reg;
    page_t page_next;
    logic  valid_reg;
    logic  valid_next;
    logic  match;

    // Compare only frames that are valid and take part in replacement.
    assign match    = valid_reg && ctl.in_range && (page_reg == ctl.page);
    assign hit_here = match && !chain_in.found;

    // Hand the match and the victim's contents down the row.
    always_comb
    begin
        chain_out.found     = chain_in.found | match;
        chain_out.rep_valid = chain_in.rep_valid | (ctl.is_victim & valid_reg);
        chain_out.rep_page  = chain_in.rep_page |
                              (ctl.is_victim ? page_reg : '0);
    end

    // Load the page on a fault at this victim; the end of a run empties it.
    always_comb
    begin
        page_next  = ctl.write ? ctl.page : page_reg;
        valid_next = ctl.clear ? 1'b0 : (ctl.write | valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/fifo_page_replacement.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement unit
// Looks a page up among the resident frames and replaces round robin on a
// fault, using a row of frame cells.
// ----------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the lookup through the row of frame cells
// and the victim pointer update both complete in the accepting cycle.
// The input stalls only while a result beat waits and the output is stalled.
// Reset empties all frames, clears the victim pointer and fault count, and
// sets frames in use to 16; no clearing pass is needed.
`default_nettype none

module fifo_page_replacement
    import fpr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic [CFG_W-1:0] cfg_write_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire fpr_in_t          in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output fpr_out_t              out_data
);

    logic [CFG_W-1:0]   frames_reg;
    idx_t               victim_reg;
    idx_t               victim_next;
    logic [FAULT_W-1:0] faults_reg;
    logic [FAULT_W-1:0] faults_next;
    logic               out_valid_reg;
    fpr_out_t           out_reg;
    fpr_out_t           out_next;

    logic [CNT_W-1:0]   active;
    idx_t               victim;
    idx_t               hit_idx;
    logic               accept;
    logic               miss;
    page_t              page;

    fpr_cell_ctl_t      ctl   [FRAME_COUNT];
    fpr_chain_t         chain [FRAME_COUNT+1];
    logic [FRAME_COUNT-1:0] hit_here;

    // Handshake: the output register parts the two sides.
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign page      = from_page_field(in_data.page_number);

    // Active frame count: zero acts as one, too large acts as FRAME_COUNT.
    always_comb
    begin
        priority if (frames_reg == '0)
            active = CNT_W'(1);
        else if (32'(frames_reg) > 32'(FRAME_COUNT))
            active = CNT_W'(FRAME_COUNT);
        else
            active = CNT_W'(frames_reg);
    end

    // Victim is slot zero when the pointer lies at or beyond the active count.
    assign victim = (32'(victim_reg) < 32'(active)) ? victim_reg : '0;

    // Row of frame cells.
    assign chain[0] = '0;
    assign miss     = ~chain[FRAME_COUNT].found;

    for (genvar i = 0; i < FRAME_COUNT; i++)
    begin : g_cell
        always_comb
        begin
            ctl[i].in_range  = 32'(i) < 32'(active);
            ctl[i].is_victim = (victim == IDX_W'(i));
            ctl[i].write     = accept & miss & (victim == IDX_W'(i));
            ctl[i].clear     = accept & in_data.last_reference;
            ctl[i].page      = page;
        end

        fpr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[i]),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .hit_here  (hit_here[i])
        );
    end

    // Encode the single first matching cell.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            if (hit_here[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    // Pointer advance with wrap, and saturating fault count.
    always_comb
    begin
        victim_next = victim_reg;
        faults_next = faults_reg;
        if (miss)
        begin
            victim_next = (32'(victim) + 32'd1 >= 32'(active)) ? '0 : victim + IDX_W'(1);
            faults_next = (faults_reg != '1) ? faults_reg + FAULT_W'(1) : faults_reg;
        end
    end

    // Result beat.
    always_comb
    begin
        out_next.hit            = ~miss;
        out_next.slot           = to_slot(miss ? victim : hit_idx);
        out_next.replaced_valid = miss & chain[FRAME_COUNT].rep_valid;
        out_next.replaced_page  = (miss & chain[FRAME_COUNT].rep_valid) ?
                                  to_page_field(chain[FRAME_COUNT].rep_page) : '0;
        out_next.fault_count    = faults_next;
        out_next.run_done       = in_data.last_reference;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= FRAMES_RESET;
            victim_reg    <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                frames_reg <= cfg_write_data;
            end
            if (accept)
            begin
                victim_reg    <= in_data.last_reference ? '0 : victim_next;
                faults_reg    <= in_data.last_reference ? '0 : faults_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fpr_check.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement port checker
// Watches the top-level ports and flags result beats that break the rules.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_check
    import fpr_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire fpr_in_t          in_data,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire fpr_out_t         out_data
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // An accepted input beat gives a result beat in the next cycle.
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted beat produced no result");

    // A hit never evicts a page.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |->
            !out_data.replaced_valid && out_data.replaced_page == '0)
        else $error("hit reported an eviction");

    // A fault is always counted.
    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.fault_count != '0)
        else $error("fault with zero fault count");

    // The run-done beat echoes the last-reference mark it was accepted with.
    a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_data.run_done == $past(in_data.last_reference))
        else $error("run done does not echo last reference");

endmodule

bind fifo_page_replacement fpr_check u_fpr_check (.*);

`default_nettype wire
